FILE: sv/ipt_pkg.sv
// shared widths, register codes and control types for the inverted page table
`default_nettype none

package ipt_pkg;

   localparam int DEF_ENTRIES = 16;

   localparam int PID_W    = 16;
   localparam int PAGE_W   = 20;
   localparam int OFFSET_W = 16;
   localparam int FIDX_W   = 4;
   localparam int PADDR_W  = 20;
   localparam int STAMP_W  = 48;

   localparam int FSIZE_W  = 17;
   localparam int FUSE_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 2'd1;

   localparam logic [FSIZE_W-1:0] FRAME_SIZE_RESET    = 17'd4096;
   localparam logic [FUSE_W-1:0]  FRAMES_IN_USE_RESET = 5'd16;

   typedef struct packed {
      logic start;
      logic scan_step;
      logic decide;
      logic addr;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/ipt_ifs.sv
// request, response and register write channel interfaces
`default_nettype none

interface ipt_req_if
   import ipt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [PID_W-1:0]    process_id;
   logic [PAGE_W-1:0]   page_number;
   logic [OFFSET_W-1:0] page_offset;

   modport source (output valid, output process_id, output page_number,
                   output page_offset, input ready);
   modport sink (input valid, input process_id, input page_number,
                 input page_offset, output ready);
endinterface

interface ipt_rsp_if
   import ipt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FIDX_W-1:0]  frame_index;
   logic [PADDR_W-1:0] physical_address;
   logic               hit;

   modport source (output valid, output frame_index, output physical_address,
                   output hit, input ready);
   modport sink (input valid, input frame_index, input physical_address,
                 input hit, output ready);
endinterface

interface ipt_csr_if
   import ipt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/ipt_ctrl.sv
// sequencer for lookup scan, replacement decision and result transfer
`default_nettype none

module ipt_ctrl
   import ipt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_ADDR   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ipt_dpath.sv
// table memories, scan trackers, access counter, address compute and output register
`default_nettype none

module ipt_dpath
   import ipt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [PID_W-1:0]      req_process_id,
   input  wire logic [PAGE_W-1:0]     req_page_number,
   input  wire logic [OFFSET_W-1:0]   req_page_offset,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [FIDX_W-1:0]          rsp_frame_index,
   output logic [PADDR_W-1:0]         rsp_physical_address,
   output logic                       rsp_hit
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW    = (IDX_W + 1 > FUSE_W) ? IDX_W + 1 : FUSE_W;

   // configuration
   logic [FSIZE_W-1:0] frame_size_ff;
   logic [FUSE_W-1:0]  frames_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff    <= FRAME_SIZE_RESET;
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_FRAME_SIZE) begin
            frame_size_ff <= csr_data[FSIZE_W-1:0];
         end else if (csr_index == CSR_FRAMES_IN_USE) begin
            frames_in_use_ff <= csr_data[FUSE_W-1:0];
         end
      end
   end

   // last index searched
   logic [CW-1:0]    fiu_ext;
   logic [CW-1:0]    last_c;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      fiu_ext = CW'(frames_in_use_ff);
      priority if (fiu_ext == '0) begin
         last_c = '0;
      end else if (fiu_ext > CW'(ENTRIES)) begin
         last_c = CW'(ENTRIES - 1);
      end else begin
         last_c = fiu_ext - CW'(1);
      end
      last_idx = last_c[IDX_W-1:0];
   end

   // latched request
   logic [PID_W-1:0]    pid_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pid_ff    <= req_process_id;
         page_ff   <= req_page_number;
         offset_ff <= req_page_offset;
      end
   end

   // table storage
   logic [PID_W-1:0]   mem_proc  [ENTRIES];
   logic [PAGE_W-1:0]  mem_page  [ENTRIES];
   logic [STAMP_W-1:0] mem_stamp [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic [IDX_W-1:0]   idx_ff;
   logic               cmp_valid_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic [PID_W-1:0]   rd_proc_ff;
   logic [PAGE_W-1:0]  rd_page_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   logic [STAMP_W-1:0] count_ff;
   logic [STAMP_W-1:0] count_next;
   logic [IDX_W-1:0]   slot_sel;
   logic [IDX_W-1:0]   slot_ff;
   logic               hit_ff;

   assign count_next = count_ff + STAMP_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_proc_ff  <= mem_proc[idx_ff];
         rd_page_ff  <= mem_page[idx_ff];
         rd_stamp_ff <= mem_stamp[idx_ff];
      end
      if (cmd.decide) begin
         mem_proc[slot_sel]  <= pid_ff;
         mem_page[slot_sel]  <= page_ff;
         mem_stamp[slot_sel] <= count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.decide) begin
            valid_ff[slot_sel] <= 1'b1;
            count_ff           <= count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.scan_step) begin
         cmp_idx_ff <= idx_ff;
      end
   end

   assign status.scan_last = (idx_ff == last_idx);

   // scan trackers
   logic               found_ff;
   logic [IDX_W-1:0]   match_idx_ff;
   logic               inv_found_ff;
   logic [IDX_W-1:0]   inv_idx_ff;
   logic               min_set_ff;
   logic [IDX_W-1:0]   min_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;
   logic               ent_valid;
   logic               ent_match;

   assign ent_valid = valid_ff[cmp_idx_ff];
   assign ent_match = ent_valid && (rd_proc_ff == pid_ff) && (rd_page_ff == page_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         found_ff     <= 1'b0;
         inv_found_ff <= 1'b0;
         min_set_ff   <= 1'b0;
      end else if (cmp_valid_ff) begin
         if (ent_match && !found_ff) begin
            found_ff     <= 1'b1;
            match_idx_ff <= cmp_idx_ff;
         end
         if (!ent_valid && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_idx_ff   <= cmp_idx_ff;
         end
         if (ent_valid && (!min_set_ff || rd_stamp_ff < min_stamp_ff)) begin
            min_set_ff   <= 1'b1;
            min_idx_ff   <= cmp_idx_ff;
            min_stamp_ff <= rd_stamp_ff;
         end
      end
   end

   always_comb begin
      priority if (found_ff) begin
         slot_sel = match_idx_ff;
      end else if (inv_found_ff) begin
         slot_sel = inv_idx_ff;
      end else begin
         slot_sel = min_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         slot_ff <= slot_sel;
         hit_ff  <= found_ff;
      end
   end

   // frame base
   logic [PADDR_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         base_ff <= PADDR_W'(slot_ff * frame_size_ff);
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic [FIDX_W-1:0]  rsp_fidx_ff;
   logic [PADDR_W-1:0] rsp_paddr_ff;
   logic               rsp_hit_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_fidx_ff  <= FIDX_W'(slot_ff);
         rsp_paddr_ff <= base_ff + PADDR_W'(offset_ff);
         rsp_hit_ff   <= hit_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_index      = rsp_fidx_ff;
   assign rsp_physical_address = rsp_paddr_ff;
   assign rsp_hit              = rsp_hit_ff;

endmodule

`default_nettype wire

FILE: sv/inverted_page_table_lru.sv
// top level of the inverted page table with least-recently-used replacement
`default_nettype none

// Fully associative inverted page table. Each request transfer carries a process
// id, page number and offset; the block searches the first frames_in_use entries
// (clamped to 1..ENTRIES) for a valid match, otherwise fills the lowest invalid
// entry or the one with the oldest access stamp, and answers with the frame
// index, frame index times frame_size plus offset (modulo 2^20) and a hit flag.
// One request is handled at a time. From accept to result register, the table
// memories are read one entry per cycle during the search, followed by one
// compare stage, the update write, the frame base multiply and the final add,
// which waits while the output register still holds an untaken result. A new
// request is accepted only once the last one is loaded into the output register.
// A finished result waits in the output register while the next request is
// accepted. No clearing pass is needed after reset. Register writes are taken at
// any time but are meant to come only while no request is in flight.

module inverted_page_table_lru
   import ipt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   ipt_req_if.sink    req_bus,
   ipt_rsp_if.source  rsp_bus,
   ipt_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   ipt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ipt_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_valid            (csr_bus.valid),
      .csr_index            (csr_bus.index),
      .csr_data             (csr_bus.data),
      .req_process_id       (req_bus.process_id),
      .req_page_number      (req_bus.page_number),
      .req_page_offset      (req_bus.page_offset),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_frame_index      (rsp_bus.frame_index),
      .rsp_physical_address (rsp_bus.physical_address),
      .rsp_hit              (rsp_bus.hit)
   );

endmodule

`default_nettype wire
